FILE: hdl/dmpa_pkg.sv
// Shared types and constants for the density matrix pair accumulator.
// No dependencies.
package dmpa_pkg;
  localparam int NumOrbitals = 32;
  localparam int Slots = 32;
  localparam int OrbLimit = (NumOrbitals > Slots) ? Slots : NumOrbitals;
  localparam int IdxW = 5;
  localparam int AddrW = 10;
  localparam int AccW = 56;
  localparam int CoefW = 24;
  localparam int ProdW = 48;
  localparam int QueueDepth = 4;
  localparam int QPtrW = 2;

  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_DIAG = 2'd0,
    OP_SINGLE = 2'd1,
    OP_READ = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // One classified command for the back end.
  typedef struct packed {
    op_t op;
    logic [31:0] alpha_occ;
    logic [31:0] beta_occ;
    logic spin;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic negate;
    logic signed [ProdW-1:0] amount;
  } cmd_t;

  function automatic logic [IdxW:0] low_bit(input logic [31:0] m);
    logic [IdxW:0] r;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      if (m[k]) r = 6'(k);
    end
    return r;
  endfunction
endpackage

FILE: hdl/density_matrix_pair_accumulator.sv
// Top level of the density matrix pair accumulator.
// Depends on dmpa_pkg, dmpa_front, dmpa_queue, dmpa_back.
//
// A one-stage front end multiplies coefficients and classifies each item;
// a four-entry queue feeds the back end, which owns two 1024 x 56 stores.
// Once the back end takes a command, a single excitation is taken, read,
// then modified and written back on one port; a read waits out any output
// stall; an identical pair is read, modified and written for each occupied
// orbital; and a clear sweeps every entry to zero. After reset the stores
// are swept to zero, and no command is executed during the sweep.
// Skipped items go no further than the front end.
module density_matrix_pair_accumulator import dmpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [31:0] alpha_occ_i,
  input  logic [31:0] beta_occ_i,
  input  logic [31:0] alpha_occ_j,
  input  logic [31:0] beta_occ_j,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic signed [CoefW-1:0] coef_j,
  input  logic [IdxW-1:0] read_row,
  input  logic [IdxW-1:0] read_col,
  input  logic read_spin,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [AccW-1:0] entry_value
);
  logic [15:0] skip_threshold;
  logic f_valid, f_stall, q_valid, q_stall;
  cmd_t f_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_threshold <= 16'd18;
    end else if (cfg_we) begin
      skip_threshold <= cfg_wdata;
    end
  end

  dmpa_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .alpha_occ_i, .beta_occ_i,
    .alpha_occ_j, .beta_occ_j, .coef_i, .coef_j, .read_row, .read_col,
    .read_spin, .thresh(skip_threshold),
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
  );

  dmpa_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_cmd)
  );

  dmpa_back u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd(q_cmd),
    .out_valid, .out_stall, .entry_value
  );
endmodule

FILE: hdl/dmpa_front.sv
// Front end: multiplies coefficients, compares determinants and classifies.
// Depends on dmpa_pkg.
module dmpa_front import dmpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [31:0] alpha_occ_i,
  input  logic [31:0] beta_occ_i,
  input  logic [31:0] alpha_occ_j,
  input  logic [31:0] beta_occ_j,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic signed [CoefW-1:0] coef_j,
  input  logic [IdxW-1:0] read_row,
  input  logic [IdxW-1:0] read_col,
  input  logic read_spin,
  input  logic [15:0] thresh,
  output logic cmd_valid,
  input  logic cmd_stall,
  output cmd_t cmd
);
  // Stage 1 registers the raw item and the product.
  logic s1_valid;
  logic [1:0] s1_kind;
  logic [31:0] s1_ai, s1_bi, s1_aj, s1_bj;
  logic signed [ProdW-1:0] s1_prod;
  logic [IdxW-1:0] s1_row, s1_col;
  logic s1_spin;

  logic [31:0] bra, ket, only_bra, only_ket, between_mask;
  logic [IdxW:0] hole, part, lo, hi;
  logic one_b, one_k, negate, same_a, same_b;
  logic [ProdW-1:0] mag;
  cmd_t c;
  logic emit;

  assign in_stall = s1_valid && cmd_valid && cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_kind <= kind;
      s1_ai <= alpha_occ_i;
      s1_bi <= beta_occ_i;
      s1_aj <= alpha_occ_j;
      s1_bj <= beta_occ_j;
      s1_prod <= ProdW'(coef_i * coef_j);
      s1_row <= read_row;
      s1_col <= read_col;
      s1_spin <= read_spin;
    end
  end

  always_comb begin
    same_a = (s1_ai == s1_aj);
    same_b = (s1_bi == s1_bj);
    bra = same_b ? s1_ai : s1_bi;
    ket = same_b ? s1_aj : s1_bj;
    only_bra = bra & ~ket;
    only_ket = ket & ~bra;
    one_b = (only_bra != '0) && ((only_bra & (only_bra - 32'd1)) == '0);
    one_k = (only_ket != '0) && ((only_ket & (only_ket - 32'd1)) == '0);
    hole = low_bit(only_bra);
    part = low_bit(only_ket);
    lo = (hole < part) ? hole : part;
    hi = (hole < part) ? part : hole;
    // bits strictly between lo and hi
    between_mask = ((32'd1 << hi[4:0]) - 32'd1) & ~((32'd2 << lo[4:0]) - 32'd1);
    negate = ^(bra & between_mask);
    mag = s1_prod[ProdW-1] ? ProdW'(-s1_prod) : ProdW'(s1_prod);
    c = '0;
    c.amount = s1_prod;
    c.alpha_occ = s1_ai;
    c.beta_occ = s1_bi;
    emit = 1'b0;
    case (s1_kind)
      KIND_ACC: begin
        if (mag >= ProdW'(thresh)) begin
          if (same_a && same_b) begin
            c.op = OP_DIAG;
            emit = 1'b1;
          end else if (same_a || same_b) begin
            c.op = OP_SINGLE;
            c.spin = same_b ? 1'b0 : 1'b1;
            c.row = part[IdxW-1:0];
            c.col = hole[IdxW-1:0];
            c.negate = negate;
            emit = one_b && one_k && (part < 6'(OrbLimit)) && (hole < 6'(OrbLimit));
          end
        end
      end
      KIND_READ: begin
        c.op = OP_READ;
        c.row = s1_row;
        c.col = s1_col;
        c.spin = s1_spin;
        emit = 1'b1;
      end
      KIND_CLEAR: begin
        c.op = OP_CLEAR;
        emit = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  assign cmd_valid = s1_valid && emit;
  assign cmd = c;
endmodule

FILE: hdl/dmpa_queue.sv
// Short command queue between front and back ends.
// Depends on dmpa_pkg.
module dmpa_queue import dmpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_stall,
  output cmd_t rd_data
);
  cmd_t slots [QueueDepth];
  logic [QPtrW-1:0] wptr, rptr;
  logic [QPtrW:0] count;
  logic push, pop;

  assign wr_stall = (count == (QPtrW+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data = slots[rptr];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end
    if (push) slots[wptr] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= (QPtrW+1)'(QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count lost push");
endmodule

FILE: hdl/dmpa_back.sv
// Back end: read-modify-write of the two density stores, reads, clears.
// Depends on dmpa_pkg.
module dmpa_back import dmpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [AccW-1:0] entry_value
);
  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_RD, ST_WR, ST_OUT
  } state_t;

  state_t state;
  logic [AccW-1:0] mem_a [Slots*Slots];
  logic [AccW-1:0] mem_b [Slots*Slots];
  logic [AccW-1:0] rd_a, rd_b;
  logic [AddrW-1:0] addr;
  logic [AddrW:0] clr_cnt;
  logic [IdxW:0] k;
  logic phase_b;
  cmd_t cur;
  logic we;
  logic clr_both;
  logic [AccW-1:0] wdata;
  logic we_spin;
  logic signed [AccW-1:0] old_v, amt;
  logic signed [AccW:0] sum;
  logic [AccW-1:0] sat;
  logic [31:0] cur_mask;
  logic [IdxW:0] next_k;
  logic found;
  logic out_load;

  assign cmd_stall = (state != ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    old_v = phase_b ? rd_b : rd_a;
    amt = AccW'(cur.negate ? -cur.amount : cur.amount);
    sum = (AccW+1)'(old_v) + (AccW+1)'(amt);
    if (sum[AccW] != sum[AccW-1])
      sat = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    else
      sat = sum[AccW-1:0];
    // next occupied orbital at or after k in current spin
    cur_mask = (phase_b ? cur.beta_occ : cur.alpha_occ) & ~((32'd1 << k[4:0]) - 32'd1);
    if (k[IdxW]) cur_mask = '0;
    found = (cur_mask != '0);
    next_k = low_bit(cur_mask);
  end

  always_ff @(posedge clk) begin
    rd_a <= mem_a[addr];
    rd_b <= mem_b[addr];
    if (we && (!we_spin || clr_both)) mem_a[addr] <= wdata;
    if (we && (we_spin || clr_both)) mem_b[addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      we <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_INIT: begin
          // sweep both stores to zero, one entry a cycle
          addr <= clr_cnt[AddrW-1:0];
          wdata <= '0;
          we <= 1'b1;
          we_spin <= 1'b0;
          clr_both <= 1'b1;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AddrW+1)'(Slots*Slots - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          we <= 1'b0;
          if (cmd_valid) begin
            cur <= cmd;
            phase_b <= (cmd.op == OP_DIAG) ? 1'b0 : cmd.spin;
            k <= '0;
            addr <= {cmd.row, cmd.col};
            case (cmd.op)
              OP_CLEAR: begin
                clr_cnt <= '0;
                state <= ST_INIT;
              end
              OP_DIAG: state <= ST_SCAN;
              default: state <= ST_RD;
            endcase
          end
        end
        ST_SCAN: begin
          // diagonal walk: pick next orbital, then read-modify-write
          we <= 1'b0;
          if (found && (next_k < (IdxW+1)'(OrbLimit))) begin
            addr <= {next_k[IdxW-1:0], next_k[IdxW-1:0]};
            k <= next_k + 1'b1;
            state <= ST_RD;
          end else if (!phase_b) begin
            phase_b <= 1'b1;
            k <= '0;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          we <= 1'b0;
          state <= (cur.op == OP_READ) ? ST_OUT : ST_WR;
        end
        ST_WR: begin
          wdata <= sat;
          we <= 1'b1;
          we_spin <= phase_b;
          clr_both <= 1'b0;
          state <= (cur.op == OP_DIAG) ? ST_SCAN : ST_IDLE;
        end
        ST_OUT: begin
          we <= 1'b0;
          if (out_load) begin
            entry_value <= cur.spin ? rd_b : rd_a;
            state <= ST_IDLE;
          end
        end
        default: begin
          we <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !(out_valid && out_stall)) |=> out_valid) else $error("read lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(entry_value)) else $error("stalled beat changed");
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> cmd_stall) else $error("command taken while busy");
endmodule

FILE: tb/sv/density_matrix_pair_accumulator_tb.sv
// Self-checking testbench for density_matrix_pair_accumulator.
// Depends on dmpa_pkg and the RTL; a local predictor keeps both density stores.
module density_matrix_pair_accumulator_tb;
  import dmpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 8000;
  localparam int CycleLimit = 3000000;
  localparam longint AccMax = 64'sd36028797018963967;
  localparam longint AccMin = -AccMax - 1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [31:0] ai, bi, aj, bj;
    logic signed [CoefW-1:0] ci, cj;
    logic [IdxW-1:0] row, col;
    logic spin;
  } pair_item_t;

  typedef struct {
    pair_item_t it;
    bit typed;
    longint value;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [31:0] alpha_occ_i = '0, beta_occ_i = '0, alpha_occ_j = '0, beta_occ_j = '0;
  logic signed [CoefW-1:0] coef_i = '0, coef_j = '0;
  logic [IdxW-1:0] read_row = '0, read_col = '0;
  logic read_spin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [AccW-1:0] entry_value;

  density_matrix_pair_accumulator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .alpha_occ_i(alpha_occ_i), .beta_occ_i(beta_occ_i),
    .alpha_occ_j(alpha_occ_j), .beta_occ_j(beta_occ_j),
    .coef_i(coef_i), .coef_j(coef_j), .read_row(read_row), .read_col(read_col),
    .read_spin(read_spin), .out_valid(out_valid), .out_stall(out_stall),
    .entry_value(entry_value)
  );

  always #10 clk = ~clk;

  // Predicted stores and register
  logic signed [AccW-1:0] alpha_store [Slots*Slots];
  logic signed [AccW-1:0] beta_store [Slots*Slots];
  logic [15:0] skip_level = 16'd18;
  logic signed [AccW-1:0] entry_due_q [$];
  logic signed [AccW-1:0] entry_due;
  directed_row_t dir_rows [$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  bit hold_off_req = 0;
  logic [IdxW-1:0] touched_row [8];
  logic [IdxW-1:0] touched_col [8];
  logic touched_spin [8];

  initial begin
    for (int k = 0; k < Slots*Slots; k++) begin
      alpha_store[k] = '0;
      beta_store[k] = '0;
    end
    for (int k = 0; k < 8; k++) begin
      touched_row[k] = '0;
      touched_col[k] = '0;
      touched_spin[k] = 1'b0;
    end
  end

  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                   input longint amount);
    longint s;
    s = longint'(a) + amount;
    if (s > AccMax) s = AccMax;
    if (s < AccMin) s = AccMin;
    return s[AccW-1:0];
  endfunction

  function automatic void queue_entry(input logic signed [AccW-1:0] v);
    entry_due_q.insert(entry_due_q.size(), v);
  endfunction

  function automatic void add_row(input pair_item_t it, input bit typed, input longint v);
    directed_row_t r;
    r.it = it;
    r.typed = typed;
    r.value = v;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void note_touch(input int r, input int c, input logic sp);
    int slot;
    slot = $urandom_range(0, 7);
    touched_row[slot] = r[IdxW-1:0];
    touched_col[slot] = c[IdxW-1:0];
    touched_spin[slot] = sp;
  endfunction

  function automatic void add_at(input logic sp, input int r, input int c, input longint amt);
    if (r >= OrbLimit || c >= OrbLimit) return;
    if (sp) beta_store[r*Slots+c] = sat_add(beta_store[r*Slots+c], amt);
    else alpha_store[r*Slots+c] = sat_add(alpha_store[r*Slots+c], amt);
    note_touch(r, c, sp);
  endfunction

  function automatic void excite_one(input logic sp, input logic [31:0] bra,
                                     input logic [31:0] ket, input longint amt);
    logic [31:0] only_bra, only_ket;
    int hole, part, lo, hi, between;
    only_bra = bra & ~ket;
    only_ket = ket & ~bra;
    if ($countones(only_bra) != 1 || $countones(only_ket) != 1) return;
    hole = 0;
    part = 0;
    between = 0;
    for (int k = 0; k < 32; k++) begin
      if (only_bra[k]) hole = k;
      if (only_ket[k]) part = k;
    end
    lo = (hole < part) ? hole : part;
    hi = (hole < part) ? part : hole;
    for (int k = lo + 1; k < hi; k++) if (bra[k]) between++;
    add_at(sp, part, hole, between[0] ? -amt : amt);
  endfunction

  // Apply one accepted beat to the predicted stores; queue any read result.
  function automatic void apply_beat(input pair_item_t it, input bit typed, input longint tv);
    longint prod, mag;
    case (it.kind)
      KIND_ACC: begin
        prod = longint'(it.ci) * longint'(it.cj);
        mag = (prod < 0) ? -prod : prod;
        if (mag >= longint'({1'b0, skip_level})) begin
          if (it.ai == it.aj && it.bi == it.bj) begin
            for (int k = 0; k < 32; k++) begin
              if (it.ai[k]) add_at(1'b0, k, k, prod);
              if (it.bi[k]) add_at(1'b1, k, k, prod);
            end
          end else if (it.bi == it.bj) begin
            excite_one(1'b0, it.ai, it.aj, prod);
          end else if (it.ai == it.aj) begin
            excite_one(1'b1, it.bi, it.bj, prod);
          end
        end
      end
      KIND_READ: begin
        if (typed) queue_entry(tv[AccW-1:0]);
        else if (it.spin) queue_entry(beta_store[it.row*Slots+it.col]);
        else queue_entry(alpha_store[it.row*Slots+it.col]);
      end
      KIND_CLEAR: begin
        for (int k = 0; k < Slots*Slots; k++) begin
          alpha_store[k] = '0;
          beta_store[k] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input pair_item_t it, input bit typed, input longint tv);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= it.kind;
    alpha_occ_i <= it.ai;
    beta_occ_i <= it.bi;
    alpha_occ_j <= it.aj;
    beta_occ_j <= it.bj;
    coef_i <= it.ci;
    coef_j <= it.cj;
    read_row <= it.row;
    read_col <= it.col;
    read_spin <= it.spin;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_beat(it, typed, tv);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (entry_due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_skip_level(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    skip_level = v;
  endtask

  function automatic pair_item_t make_read(input int r, input int c, input logic sp);
    pair_item_t it;
    it.kind = KIND_READ;
    it.ai = $urandom; it.bi = $urandom; it.aj = $urandom; it.bj = $urandom;
    it.ci = CoefW'($urandom); it.cj = CoefW'($urandom);
    it.row = r[IdxW-1:0];
    it.col = c[IdxW-1:0];
    it.spin = sp;
    return it;
  endfunction

  function automatic pair_item_t make_acc(input logic [31:0] ai, input logic [31:0] bi,
                                          input logic [31:0] aj, input logic [31:0] bj,
                                          input int ci, input int cj);
    pair_item_t it;
    it.kind = KIND_ACC;
    it.ai = ai; it.bi = bi; it.aj = aj; it.bj = bj;
    it.ci = ci[CoefW-1:0];
    it.cj = cj[CoefW-1:0];
    it.row = IdxW'($urandom); it.col = IdxW'($urandom); it.spin = 1'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] move_one(input logic [31:0] bra);
    int hole, part;
    if (bra == '0 || bra == '1) bra = 32'h0000_0f0f;
    do hole = $urandom_range(0, 31); while (!bra[hole]);
    do part = $urandom_range(0, 31); while (bra[part]);
    return bra ^ (32'd1 << hole) ^ (32'd1 << part);
  endfunction

  function automatic pair_item_t random_beat();
    pair_item_t it;
    int pick, ci, cj, slot;
    logic [31:0] a, b;
    pick = $urandom_range(0, 99);
    ci = $urandom;
    cj = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      ci = $urandom_range(0, 16) - 8;
      cj = $urandom_range(0, 16) - 8;
    end
    a = $urandom;
    b = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      a = a & $urandom;
      b = b & $urandom;
    end
    if (pick < 15) it = make_acc(a, b, a, b, ci, cj);
    else if (pick < 33) it = make_acc(a, b, move_one(a), b, ci, cj);
    else if (pick < 51) it = make_acc(a, b, a, move_one(b), ci, cj);
    else if (pick < 55) it = make_acc(a, b, move_one(a), move_one(b), ci, cj);
    else if (pick < 60) it = make_acc(a, b, $urandom, $urandom, ci, cj);
    else if (pick < 62) begin
      it = make_read(0, 0, 1'b0);
      it.kind = (pick == 60) ? KIND_CLEAR : KIND_UNUSED;
    end else if (pick < 85) begin
      slot = $urandom_range(0, 7);
      it = make_read(int'(touched_row[slot]), int'(touched_col[slot]), touched_spin[slot]);
    end else begin
      it = make_read($urandom_range(0, 31), $urandom_range(0, 31), 1'($urandom));
    end
    return it;
  endfunction

  // Receiver: random stall per beat, with an occasional long hold-off.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (entry_due_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0d", $time, entry_value);
        errors++;
      end else begin
        entry_due = entry_due_q.pop_front();
        if (entry_value !== entry_due) begin
          $display("%0t: entry_value mismatch, expected %0d, actual %0d",
                   $time, entry_due, entry_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    directed_row_t dr;
    pair_item_t it;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset threshold of 18 stays in force for the directed rows.
    add_row(make_read(0, 0, 1'b0), 1, 0);
    add_row(make_read(31, 31, 1'b1), 1, 0);
    add_row(make_acc(32'h1, 32'h1, 32'h1, 32'h1, 1, 1), 0, 0);
    add_row(make_read(0, 0, 1'b0), 1, 0);
    add_row(make_acc(32'h8000_0001, 32'h2, 32'h8000_0001, 32'h2,
                     'h400000, 'h400000), 0, 0);
    add_row(make_read(31, 31, 1'b0), 1, 64'sd1 <<< 44);
    add_row(make_read(1, 1, 1'b1), 1, 64'sd1 <<< 44);
    add_row(make_acc(32'h5, 32'h0, 32'h6, 32'h0, 'h400000, -'h400000), 0, 0);
    add_row(make_read(1, 0, 1'b0), 0, 0);
    // odd count between hole and particle
    add_row(make_acc(32'h8000_0005, 32'h0, 32'h8000_0024, 32'h0,
                     'h400000, 'h400000), 0, 0);
    add_row(make_read(5, 0, 1'b0), 0, 0);
    add_row(make_acc(32'hf, 32'h1, 32'hf, 32'h8000_0000,
                     'h7fffff, -'h800000), 0, 0);
    add_row(make_read(31, 0, 1'b1), 0, 0);
    // both spins differ by one: no update
    add_row(make_acc(32'h1, 32'h1, 32'h2, 32'h2, 'h400000, 'h400000), 0, 0);
    add_row(make_read(1, 0, 1'b1), 0, 0);
    add_row(make_acc(32'h3, 32'h0, 32'hc, 32'h0, 'h400000, 'h400000), 0, 0);
    add_row(make_acc(32'h1, 32'h0, 32'h3, 32'h0, 'h400000, 'h400000), 0, 0);
    add_row(make_read(2, 3, 1'b0), 0, 0);
    it = make_read(0, 0, 1'b0);
    it.kind = KIND_UNUSED;
    add_row(it, 0, 0);
    add_row(make_acc('1, '1, '1, '1, -'h800000, -'h800000), 0, 0);
    add_row(make_read(17, 17, 1'b1), 1, 64'sd1 <<< 46);
    it.kind = KIND_CLEAR;
    add_row(it, 0, 0);
    add_row(make_read(17, 17, 1'b1), 1, 0);
    add_row(make_acc(32'h4, 32'h0, 32'h4, 32'h0, 3, 6), 0, 0);
    add_row(make_acc(32'h4, 32'h0, 32'h4, 32'h0, -1, 17), 0, 0);
    add_row(make_read(2, 2, 1'b0), 1, 18);
    foreach (dir_rows[k]) begin
      dr = dir_rows[k];
      send_beat(dr.it, dr.typed, dr.value);
    end
    drain_block();

    write_skip_level(16'd0);
    for (int k = 0; k < 40; k++) begin
      if (k == 20) no_idle = 1;
      if (k == 28) no_idle = 0;
      send_beat(random_beat(), 0, 0);
    end

    // Hold the receiver off while reads keep coming, so the queue backs up.
    hold_off_req = 1;
    no_idle = 1;
    for (int k = 0; k < 20; k++)
      send_beat(make_read($urandom_range(0, 31), $urandom_range(0, 31), 1'($urandom)), 0, 0);
    no_idle = 0;
    drain_block();

    write_skip_level(16'hffff);
    for (int k = 0; k < 15; k++) send_beat(random_beat(), 0, 0);
    drain_block();

    // Drive one diagonal entry of each store into the upper limit.
    write_skip_level(16'($urandom));
    it.kind = KIND_CLEAR;
    send_beat(it, 0, 0);
    no_idle = 1;
    for (int k = 0; k < 513; k++)
      send_beat(make_acc(32'h1, 32'h1, 32'h1, 32'h1, -'h800000, -'h800000), 0, 0);
    send_beat(make_read(0, 0, 1'b0), 1, AccMax);
    send_beat(make_read(0, 0, 1'b1), 1, AccMax);
    no_idle = 0;
    drain_block();

    write_skip_level(16'd1);
    for (int k = 0; k < 15; k++) send_beat(random_beat(), 0, 0);
    drain_block();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
